// ----- rtl/utf8d_pkg.sv -----
// Shared types for the UTF-8 to UCS-4 decoder.
package utf8d_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CapWidth  = 16;
  localparam int unsigned PendWidth = 3;

  localparam logic [ByteWidth-1:0] ContLow  = 8'h80;
  localparam logic [ByteWidth-1:0] Lead2Low = 8'hC0;
  localparam logic [ByteWidth-1:0] Lead3Low = 8'hE0;
  localparam logic [ByteWidth-1:0] Lead4Low = 8'hF0;
  localparam logic [ByteWidth-1:0] Lead5Low = 8'hF8;
  localparam logic [ByteWidth-1:0] Lead6Low = 8'hFC;
  localparam logic [ByteWidth-1:0] BadLow   = 8'hFE;
  localparam int unsigned          ContBits = 6;

  // Decoder state apart from the per-string counter
  typedef struct packed {
    logic [PendWidth-1:0] bytes_pending;
    logic                 skipping;
    logic [CpWidth-1:0]   accumulator;
    logic                 discard_rest;
  } dec_state_t;

  // Per-item result of the decode step
  typedef struct packed {
    logic               emit;
    logic               term;
    logic               last;
    logic [CpWidth-1:0] code_point;
  } dec_result_t;

endpackage

// ----- rtl/utf8d_step.sv -----
// One-byte decode step: next state and optional code point from current state.
module utf8d_step #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  utf8d_pkg::dec_state_t                  state_i,
  input  logic [COUNT_WIDTH-1:0]                 count_i,
  input  logic [utf8d_pkg::CapWidth-1:0]         capacity_i,
  input  logic [utf8d_pkg::ByteWidth-1:0]        byte_i,
  output utf8d_pkg::dec_state_t                  state_o,
  output logic [COUNT_WIDTH-1:0]                 count_o,
  output logic [utf8d_pkg::CapWidth-1:0]         written_o,
  output utf8d_pkg::dec_result_t                 result_o
);
  import utf8d_pkg::*;

  // Compare width covers both the counter and the capacity register
  localparam int unsigned LimW = (COUNT_WIDTH > CapWidth) ? COUNT_WIDTH : CapWidth;

  logic [LimW-1:0]        cap_ext;
  logic [LimW-1:0]        max_ext;
  logic [LimW-1:0]        limit;
  logic [LimW-1:0]        cnt_ext;
  logic [LimW-1:0]        cnt_inc_ext;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CpWidth-1:0]     acc_shift;
  logic [PendWidth-1:0]   pend_dec;

  // Limit is capacity clipped to the counter range
  assign cap_ext     = LimW'(capacity_i);
  assign max_ext     = LimW'({COUNT_WIDTH{1'b1}});
  assign limit       = (cap_ext < max_ext) ? cap_ext : max_ext;
  assign cnt_ext     = LimW'(count_i);
  assign cnt_inc     = count_i + COUNT_WIDTH'(1);
  assign cnt_inc_ext = LimW'(cnt_inc);
  assign acc_shift   = {state_i.accumulator[CpWidth-ContBits-1:0], byte_i[ContBits-1:0]};
  assign pend_dec    = state_i.bytes_pending - PendWidth'(1);
  assign written_o   = cnt_inc_ext[CapWidth-1:0];

  always_comb begin
    state_o  = state_i;
    count_o  = count_i;
    result_o = '0;

    if (state_i.bytes_pending != '0) begin
      // Following byte of a sequence
      state_o.bytes_pending = pend_dec;
      if (state_i.skipping) begin
        if (pend_dec == '0) begin
          state_o.skipping = 1'b0;
        end
      end else begin
        state_o.accumulator = acc_shift;
        if (pend_dec == '0) begin
          result_o.emit       = 1'b1;
          result_o.code_point = acc_shift;
        end
      end
    end else if (state_i.discard_rest || (cnt_ext >= limit)) begin
      // Past the limit: drop up to the terminator
      state_o.discard_rest = 1'b1;
      if (byte_i == '0) begin
        state_o = '0;
        count_o = '0;
      end
    end else if (byte_i < ContLow) begin
      result_o.emit       = 1'b1;
      result_o.term       = (byte_i == '0);
      result_o.code_point = CpWidth'(byte_i);
    end else if ((byte_i < Lead2Low) || (byte_i >= BadLow)) begin
      // Lone continuation or invalid byte: dropped
    end else if (byte_i < Lead3Low) begin
      state_o.accumulator   = CpWidth'(byte_i[4:0]);
      state_o.bytes_pending = PendWidth'(1);
    end else if (byte_i < Lead4Low) begin
      state_o.accumulator   = CpWidth'(byte_i[3:0]);
      state_o.bytes_pending = PendWidth'(2);
    end else if (byte_i < Lead5Low) begin
      state_o.accumulator   = CpWidth'(byte_i[2:0]);
      state_o.bytes_pending = PendWidth'(3);
    end else if (byte_i < Lead6Low) begin
      state_o.skipping      = 1'b1;
      state_o.bytes_pending = PendWidth'(4);
    end else begin
      state_o.skipping      = 1'b1;
      state_o.bytes_pending = PendWidth'(5);
    end

    // Emission bumps the counter and may close the string
    if (result_o.emit) begin
      count_o       = cnt_inc;
      result_o.last = result_o.term || (cnt_inc_ext >= limit);
      if (result_o.term) begin
        state_o = '0;
        count_o = '0;
      end else if (result_o.last) begin
        state_o.discard_rest = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/utf8_to_ucs4_decoder_core.sv -----
// Top level of the UTF-8 to UCS-4 decoder with APB capacity register.
//
// Usage: one byte of a zero-terminated UTF-8 string enters per item on the
// in_valid_i/in_ready_o channel. Decoded code points leave on the
// out_valid_o/out_ready_i channel with the per-string count and a last flag
// (set on the terminator or when the capacity limit is reached).
// A code point is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the decode step is a single combinational
// stage feeding the result register, with the state registers looping back.
// A stalled receiver holds the result register; input is still taken as long
// as the result register is empty or being drained in the same cycle.
// Reset clears all decode state and sets capacity to 65535; the capacity
// register sits at byte address 0 of the APB port and takes effect from the
// next byte taken after the write.
module utf8_to_ucs4_decoder_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // byte input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [utf8d_pkg::ByteWidth-1:0]     in_byte_i,
  // code point output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [utf8d_pkg::CpWidth-1:0]       code_point_o,
  output logic [utf8d_pkg::CapWidth-1:0]      written_count_o,
  output logic                                last_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [1:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import utf8d_pkg::*;

  localparam logic [1:0] AddrCapacity = 2'd0;

  dec_state_t             state_q, state_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [CapWidth-1:0]    capacity_q;
  logic [CapWidth-1:0]    written;
  dec_result_t            res;
  logic                   in_fire;
  logic                   cfg_write;

  logic                   out_valid_q;
  logic [CpWidth-1:0]     code_point_q;
  logic [CapWidth-1:0]    written_count_q;
  logic                   last_q;

  // Handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Decode step
  utf8d_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .state_i    (state_q),
    .count_i    (count_q),
    .capacity_i (capacity_q),
    .byte_i     (in_byte_i),
    .state_o    (state_d),
    .count_o    (count_d),
    .written_o  (written),
    .result_o   (res)
  );

  // Decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      count_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res.emit) begin
      code_point_q    <= res.code_point;
      written_count_q <= written;
      last_q          <= res.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign code_point_o    = code_point_q;
  assign written_count_o = written_count_q;
  assign last_o          = last_q;

  // APB capacity register
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr == AddrCapacity) ? 32'(capacity_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '1;
    end else if (cfg_write && (paddr == AddrCapacity)) begin
      capacity_q <= pwdata[CapWidth-1:0];
    end
  end

  // Assertions
  a_skip_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.skipping |-> state_q.bytes_pending != '0)
    else $error("skipping without pending bytes");

  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_pending <= 3'd5)
    else $error("pending byte count out of range");

  a_term_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res.emit && res.term) |=> (count_q == '0 && state_q == '0))
    else $error("terminator did not restart the decoder");

endmodule
